>>> rtl/uartrb_pkg.sv
// package for the uart transmit / receive ring buffer block
// holds opcode codes, field widths and default ring size; no dependencies
package uartrb_pkg;

  // ring depth default
  localparam int BUF_SIZE_DEF = 256;

  // field widths
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int STAT_W  = 8;
  localparam int CNT16_W = 16;

  typedef logic [OP_W-1:0] opcode_t;

  // opcodes
  localparam opcode_t OP_PUSH_TX  = 3'd0;
  localparam opcode_t OP_TX_READY = 3'd1;
  localparam opcode_t OP_RX_ARRIVE = 3'd2;
  localparam opcode_t OP_RX_READ  = 3'd3;
  localparam opcode_t OP_DMA_KICK = 3'd4;
  localparam opcode_t OP_DMA_DONE = 3'd5;
  localparam opcode_t OP_DMA_HALF = 3'd6;
  localparam opcode_t OP_NOP      = 3'd7;

endpackage

>>> rtl/uart_ring_buffers_dma_tx.sv
// uart transmit and receive ring buffers with a dma chunk transmit path
// top level; depends on uartrb_pkg
//
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall   | in_opcode, in_data_byte
// out_     | output    | out_valid/out_stall | out_out_byte .. out_tx_overrun_count
// cfg_     | input     | cfg_valid/cfg_ready | cfg_dma_mode
//
// one item per cycle sustained while the output does not stall; a transfer lands in the
// input register, and its result moves on into the result register as the item advances
// ring updates are one read port and one write port per ring memory per cycle
// reset is synchronous; the ring memories are not cleared
// an output stall holds the result and the state, and backs up into in_stall
module uart_ring_buffers_dma_tx #(
  parameter int BUF_SIZE = uartrb_pkg::BUF_SIZE_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  uartrb_pkg::opcode_t       in_opcode,
  input  logic [7:0]                in_data_byte,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_out_byte,
  output logic                      out_byte_valid,
  output logic                      out_accepted,
  output logic [7:0]                out_tx_used,
  output logic [7:0]                out_tx_free,
  output logic [7:0]                out_rx_waiting,
  output logic [7:0]                out_dma_start_index,
  output logic [7:0]                out_dma_count,
  output logic                      out_dma_busy,
  output logic                      out_tx_irq_enable,
  output logic [15:0]               out_rx_overrun_count,
  output logic [15:0]               out_tx_overrun_count,
  // configuration
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_dma_mode
);
  import uartrb_pkg::*;

  localparam int IDX_W = $clog2(BUF_SIZE);
  localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W+1)'(BUF_SIZE);
  localparam logic [IDX_W-1:0] MAX_USED = IDX_W'(BUF_SIZE - 1);

  // ring helpers
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [IDX_W-1:0] n);
    logic [IDX_W:0] s;
    s = {1'b0, idx} + {1'b0, n};
    if (s >= SIZE_EXT) s = s - SIZE_EXT;
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_used(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] tail);
    logic [IDX_W:0] d;
    d = {1'b0, tail} - {1'b0, head};
    if (tail < head) d = d + SIZE_EXT;
    return d[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] chunk_cnt(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] tail);
    logic [IDX_W:0] d;
    if (tail >= head) d = {1'b0, tail} - {1'b0, head};
    else d = SIZE_EXT - {1'b0, head};
    return d[IDX_W-1:0];
  endfunction

  function automatic logic [7:0] low8(input logic [IDX_W-1:0] v);
    logic [IDX_W+7:0] e;
    e = {8'd0, v};
    return e[7:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  // ring memories
  logic [7:0] tx_mem [BUF_SIZE];
  logic [7:0] rx_mem [BUF_SIZE];

  // input register
  logic       s1_valid_r;
  opcode_t    s1_op_r;
  logic [7:0] s1_data_r;

  // block state
  logic             dma_mode_r;
  logic [IDX_W-1:0] tx_head_r, tx_head_nxt;
  logic [IDX_W-1:0] tx_tail_r, tx_tail_nxt;
  logic [IDX_W-1:0] rx_head_r, rx_head_nxt;
  logic [IDX_W-1:0] rx_tail_r, rx_tail_nxt;
  logic [IDX_W-1:0] chunk_len_r, chunk_len_nxt;
  logic             chunk_act_r, chunk_act_nxt;
  logic             irq_en_r, irq_en_nxt;
  logic [15:0]      rx_lost_r, rx_lost_nxt;
  logic [15:0]      tx_refused_r, tx_refused_nxt;

  // result register
  logic       out_valid_r;
  logic       pop_tx_r, pop_tx_nxt;
  logic       pop_rx_r, pop_rx_nxt;
  logic       acc_r, acc_nxt;
  logic [7:0] tx_rd_r;
  logic [7:0] rx_rd_r;

  logic             adv;
  logic             proc;
  logic             tx_we;
  logic             rx_we;
  logic [IDX_W-1:0] tx_used;
  logic [IDX_W-1:0] dma_head;
  logic [IDX_W-1:0] half_len;

  // handshake
  assign adv       = !out_valid_r || !out_stall;
  assign proc      = s1_valid_r && adv;
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dma_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      dma_mode_r <= cfg_dma_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= in_opcode;
      s1_data_r <= in_data_byte;
    end
  end

  assign tx_used  = ring_used(tx_head_r, tx_tail_r);
  assign dma_head = wrap_add(tx_head_r, chunk_len_r);
  assign half_len = chunk_len_r >> 1;

  // next state for the item in the input register
  always_comb begin
    tx_head_nxt    = tx_head_r;
    tx_tail_nxt    = tx_tail_r;
    rx_head_nxt    = rx_head_r;
    rx_tail_nxt    = rx_tail_r;
    chunk_len_nxt  = chunk_len_r;
    chunk_act_nxt  = chunk_act_r;
    irq_en_nxt     = irq_en_r;
    rx_lost_nxt    = rx_lost_r;
    tx_refused_nxt = tx_refused_r;
    pop_tx_nxt     = 1'b0;
    pop_rx_nxt     = 1'b0;
    acc_nxt        = 1'b0;
    tx_we          = 1'b0;
    rx_we          = 1'b0;
    case (s1_op_r)
      OP_PUSH_TX: begin
        if (tx_used == MAX_USED) begin
          tx_refused_nxt = sat_inc(tx_refused_r);
          if (dma_mode_r && !chunk_act_r) begin
            chunk_len_nxt = chunk_cnt(tx_head_r, tx_tail_r);
            chunk_act_nxt = (chunk_len_nxt != '0);
          end
        end else begin
          tx_we       = 1'b1;
          tx_tail_nxt = wrap_add(tx_tail_r, IDX_W'(1));
          acc_nxt     = 1'b1;
          if (!dma_mode_r) irq_en_nxt = 1'b1;
        end
      end
      OP_TX_READY: begin
        if (!dma_mode_r && irq_en_r) begin
          if (tx_head_r != tx_tail_r) begin
            pop_tx_nxt  = 1'b1;
            tx_head_nxt = wrap_add(tx_head_r, IDX_W'(1));
          end else begin
            irq_en_nxt = 1'b0;
          end
        end
      end
      OP_RX_ARRIVE: begin
        rx_we       = 1'b1;
        rx_tail_nxt = wrap_add(rx_tail_r, IDX_W'(1));
        if (rx_head_r == rx_tail_nxt) begin
          rx_lost_nxt = sat_inc(rx_lost_r);
          rx_head_nxt = wrap_add(rx_head_r, IDX_W'(1));
        end
      end
      OP_RX_READ: begin
        if (rx_head_r != rx_tail_r) begin
          pop_rx_nxt  = 1'b1;
          rx_head_nxt = wrap_add(rx_head_r, IDX_W'(1));
        end
      end
      OP_DMA_KICK: begin
        if (dma_mode_r && !chunk_act_r) begin
          chunk_len_nxt = chunk_cnt(tx_head_r, tx_tail_r);
          chunk_act_nxt = (chunk_len_nxt != '0);
        end
      end
      OP_DMA_DONE: begin
        if (chunk_act_r) begin
          tx_head_nxt   = dma_head;
          chunk_act_nxt = 1'b0;
          chunk_len_nxt = '0;
          if (dma_mode_r) begin
            chunk_len_nxt = chunk_cnt(dma_head, tx_tail_r);
            chunk_act_nxt = (chunk_len_nxt != '0);
          end
        end
      end
      OP_DMA_HALF: begin
        if (chunk_act_r) begin
          tx_head_nxt   = wrap_add(tx_head_r, half_len);
          chunk_len_nxt = chunk_len_r - half_len;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // state update, one item per transfer out of the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r    <= '0;
      tx_tail_r    <= '0;
      rx_head_r    <= '0;
      rx_tail_r    <= '0;
      chunk_len_r  <= '0;
      chunk_act_r  <= 1'b0;
      irq_en_r     <= 1'b0;
      rx_lost_r    <= '0;
      tx_refused_r <= '0;
    end else if (proc) begin
      tx_head_r    <= tx_head_nxt;
      tx_tail_r    <= tx_tail_nxt;
      rx_head_r    <= rx_head_nxt;
      rx_tail_r    <= rx_tail_nxt;
      chunk_len_r  <= chunk_len_nxt;
      chunk_act_r  <= chunk_act_nxt;
      irq_en_r     <= irq_en_nxt;
      rx_lost_r    <= rx_lost_nxt;
      tx_refused_r <= tx_refused_nxt;
    end
  end

  // transmit ring memory, write at tail and registered read at head
  always_ff @(posedge clk) begin
    if (proc && tx_we) begin
      tx_mem[tx_tail_r] <= s1_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      tx_rd_r <= tx_mem[tx_head_r];
    end
  end

  // receive ring memory, write at tail and registered read at head
  always_ff @(posedge clk) begin
    if (proc && rx_we) begin
      rx_mem[rx_tail_r] <= s1_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      rx_rd_r <= rx_mem[rx_head_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pop_tx_r    <= 1'b0;
      pop_rx_r    <= 1'b0;
      acc_r       <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        pop_tx_r <= pop_tx_nxt;
        pop_rx_r <= pop_rx_nxt;
        acc_r    <= acc_nxt;
      end
    end
  end

  // result fields; state only moves with a new result, so it reads as post-step
  assign out_valid            = out_valid_r;
  assign out_out_byte         = pop_tx_r ? tx_rd_r : (pop_rx_r ? rx_rd_r : 8'd0);
  assign out_byte_valid       = pop_tx_r || pop_rx_r;
  assign out_accepted         = acc_r;
  assign out_tx_used          = low8(tx_used);
  assign out_tx_free          = low8(MAX_USED - tx_used);
  assign out_rx_waiting       = low8(ring_used(rx_head_r, rx_tail_r));
  assign out_dma_start_index  = chunk_act_r ? low8(tx_head_r) : 8'd0;
  assign out_dma_count        = chunk_act_r ? low8(chunk_len_r) : 8'd0;
  assign out_dma_busy         = chunk_act_r;
  assign out_tx_irq_enable    = irq_en_r;
  assign out_rx_overrun_count = rx_lost_r;
  assign out_tx_overrun_count = tx_refused_r;

endmodule

>>> rtl/uartrb_chk.sv
// port level checks for the uart ring buffer block
// bound to uart_ring_buffers_dma_tx; depends on uartrb_pkg
module uartrb_chk #(
  parameter int BUF_SIZE = uartrb_pkg::BUF_SIZE_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_out_byte,
  input logic        out_byte_valid,
  input logic        out_accepted,
  input logic [7:0]  out_tx_used,
  input logic [7:0]  out_tx_free,
  input logic [7:0]  out_dma_start_index,
  input logic [7:0]  out_dma_count,
  input logic        out_dma_busy
);
  import uartrb_pkg::*;

  localparam logic [7:0] FREE_SUM = 8'(BUF_SIZE - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_byte)
      && $stable(out_tx_used) && $stable(out_accepted))
    else $error("stalled result changed");

  // a transfer never both pops and stores a byte
  a_pop_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_byte_valid && out_accepted))
    else $error("pop and push in one result");

  // no popped byte means a zero byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_out_byte == 8'd0)
    else $error("byte shown without pop");

  // used and free always add up to the ring size minus one
  a_free_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 8'(out_tx_used + out_tx_free) == FREE_SUM)
    else $error("used plus free mismatch");

  // an idle dma engine shows no chunk
  a_dma_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dma_busy |-> out_dma_count == 8'd0
      && out_dma_start_index == 8'd0)
    else $error("chunk shown while dma idle");

endmodule

bind uart_ring_buffers_dma_tx uartrb_chk #(.BUF_SIZE(BUF_SIZE)) u_uartrb_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_out_byte        (out_out_byte),
  .out_byte_valid      (out_byte_valid),
  .out_accepted        (out_accepted),
  .out_tx_used         (out_tx_used),
  .out_tx_free         (out_tx_free),
  .out_dma_start_index (out_dma_start_index),
  .out_dma_count       (out_dma_count),
  .out_dma_busy        (out_dma_busy)
);
